[rtl/core/i2cms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master message sequencer: shared definitions
// Request and result payload types, the front-to-back command word, the
// controller register bit positions and the outcome codes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Fixed field widths of the request and result payloads.
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 3;
    localparam int LEN_W   = 8;

    // Default descriptor table size and the longest message in bytes.
    localparam int C_MAX_MESSAGES_DEF = 8;
    localparam int C_MAX_BYTES        = 255;

    // Slots that a load request can address at all.
    localparam int C_SLOT_SPAN = 2 ** SLOT_W;

    localparam logic [6:0]  C_ADDR_MASK   = 7'h7f;
    localparam logic [31:0] C_STATUS_MASK = 32'hfffc_0000;

    // Control register bits.
    localparam logic [31:0] CB_START     = 32'h1 << 0;
    localparam logic [31:0] CB_STOP      = 32'h1 << 1;
    localparam logic [31:0] CB_ACKNAK    = 32'h1 << 2;
    localparam logic [31:0] CB_TB        = 32'h1 << 3;
    localparam logic [31:0] CB_MODE_FAST = 32'h1 << 8;
    localparam logic [31:0] CB_SCLE      = 32'h1 << 13;
    localparam logic [31:0] CB_IUE       = 32'h1 << 14;
    localparam logic [31:0] CB_ALDIE     = 32'h1 << 18;
    localparam logic [31:0] CB_DTEIE     = 32'h1 << 19;
    localparam logic [31:0] CB_DRFIE     = 32'h1 << 20;
    localparam logic [31:0] CB_GCD       = 32'h1 << 21;
    localparam logic [31:0] CB_BEIE      = 32'h1 << 22;
    localparam logic [31:0] CB_MSDIE     = 32'h1 << 25;
    localparam logic [31:0] CB_MSDE      = 32'h1 << 26;
    localparam logic [31:0] CB_TXDONEIE  = 32'h1 << 27;
    localparam logic [31:0] CB_TXEIE     = 32'h1 << 28;
    localparam logic [31:0] CB_RXHFIE    = 32'h1 << 29;
    localparam logic [31:0] CB_RXFIE     = 32'h1 << 30;
    localparam logic [31:0] CB_RXOVIE    = 32'h1 << 31;

    localparam logic [31:0] CB_INT_ALL = CB_ALDIE | CB_DTEIE | CB_DRFIE | CB_BEIE
                                       | CB_TXDONEIE | CB_TXEIE | CB_RXHFIE
                                       | CB_RXFIE | CB_RXOVIE | CB_MSDIE;

    localparam logic [31:0] CB_INIT = CB_BEIE | CB_ALDIE | CB_DRFIE | CB_MODE_FAST
                                    | CB_GCD | CB_SCLE | CB_MSDE | CB_MSDIE | CB_IUE;

    // Status register bit positions.
    localparam int SB_RWM    = 13;
    localparam int SB_ACKNAK = 14;
    localparam int SB_ALD    = 18;
    localparam int SB_ITE    = 19;
    localparam int SB_IRF    = 20;
    localparam int SB_BED    = 22;
    localparam int SB_MSD    = 26;
    localparam int SB_RXOV   = 31;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_EVENT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        OC_OK        = 2'd0,
        OC_RETRY     = 2'd1,
        OC_NO_DEVICE = 2'd2,
        OC_IO_ERROR  = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_LOAD  = 2'd1,
        K_START = 2'd2,
        K_EVENT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         action;
        logic [SLOT_W-1:0]  slot;
        logic [6:0]         target_address;
        logic               is_read;
        logic [LEN_W-1:0]   byte_length;
        logic [COUNT_W-1:0] message_count;
        logic [31:0]        status_word;
        logic [7:0]         received_byte;
        logic [7:0]         send_byte;
    } t_request;

    typedef struct packed {
        logic               control_write;
        logic [31:0]        control_value;
        logic               data_write;
        logic [7:0]         data_value;
        logic               send_taken;
        logic               store_valid;
        logic [7:0]         store_byte;
        logic [31:0]        status_clear;
        logic               unit_reset;
        logic               finished;
        logic [1:0]         outcome;
        logic [INDEX_W-1:0] current_message;
    } t_result;

    // Classified request as it travels from the front end to the back end.
    typedef struct packed {
        t_kind              kind;
        logic               slot_ok;
        logic [SLOT_W-1:0]  slot;
        logic [15:0]        desc;
        logic [COUNT_W-1:0] count;
        logic [31:0]        clr;
        logic               err;
        logic               ureset;
        t_outcome           oc;
        logic               irf;
        logic               ite;
        logic               rwm;
        logic               msd;
        logic               acknak;
        logic [7:0]         recv;
        logic [7:0]         send;
    } t_cmd;

endpackage

[rtl/core/i2c_master_message_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master message sequencer
// Steps a byte-mode I2C controller through a list of up to MAX_MESSAGES
// messages, one request per load, start or controller status event.
// ----------------------------------------------------------------------------
// The block takes one request per clock while its command queue has room and
// returns exactly one result per request, in order. A request accepted at one
// clock edge is decoded by the front end and written into a two-entry command
// queue at that same edge; the back end executes it once it reaches the head
// of the queue and the result register is free or being taken, and registers
// the result. A new request can be accepted every cycle, which is the
// sustained rate as long as results are taken. The back end executes each
// command as one combinational update of control word, message index and
// byte count, with no iteration, which is what sustains that rate. When the
// result register is stalled the queue absorbs requests until both of its
// entries are filled, and then the input stalls. Load requests fill a
// descriptor table of min(MAX_MESSAGES, 8) slots; a slot that was never
// loaded must not be started from, as its contents are undefined. Start
// requests (re)open the list at message 0 and status events drive the
// transfer until an error or a master stop ends it with one outcome code.
// The block assumes the controller's control register reads back the last
// value that the block wrote.
// ----------------------------------------------------------------------------
module i2c_master_message_sequencer #(
    parameter int MAX_MESSAGES = i2cms_pkg::C_MAX_MESSAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i2cms_pkg::t_request i_in_req,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cms_pkg::t_result  o_out_res
);

    i2cms_pkg::t_cmd w_front_cmd;
    i2cms_pkg::t_cmd w_queue_cmd;
    logic            w_queue_full;
    logic            w_queue_valid;
    logic            w_pop;
    logic            w_push;

    // A request is accepted whenever the queue has room; the stall depends
    // only on the queue level, never on the incoming valid.
    assign o_in_stall = w_queue_full;
    assign w_push     = i_in_valid && !w_queue_full;

    // Front end: classification of each request.
    i2cms_front #(
        .MAX_MESSAGES (MAX_MESSAGES)
    ) u_front (
        .i_req (i_in_req),
        .o_cmd (w_front_cmd)
    );

    // Short queue so that front and back can stall independently.
    i2cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd)
    );

    // Back end: descriptor table, transfer state and result register.
    i2cms_back #(
        .MAX_MESSAGES (MAX_MESSAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_res       (o_out_res)
    );

endmodule

[rtl/core/i2cms_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C message sequencer: front end
// Decodes each incoming request into a command word: descriptor packing,
// count clamping and status-word classification, including the error outcome.
// ----------------------------------------------------------------------------
module i2cms_front #(
    parameter int MAX_MESSAGES = i2cms_pkg::C_MAX_MESSAGES_DEF
) (
    input  i2cms_pkg::t_request i_req,
    output i2cms_pkg::t_cmd     o_cmd
);

    localparam int TblDepth = (MAX_MESSAGES < i2cms_pkg::C_SLOT_SPAN)
                            ? MAX_MESSAGES : i2cms_pkg::C_SLOT_SPAN;

    logic [i2cms_pkg::LEN_W-1:0]   v_len;
    logic [i2cms_pkg::COUNT_W-1:0] v_cnt;
    logic [31:0]                   v_st;
    logic                          v_bed;
    logic                          v_rxov;
    logic                          v_ald;

    assign v_st   = i_req.status_word;
    assign v_bed  = v_st[i2cms_pkg::SB_BED];
    assign v_rxov = v_st[i2cms_pkg::SB_RXOV];
    assign v_ald  = v_st[i2cms_pkg::SB_ALD];

    always_comb begin
        v_len = i_req.byte_length;
        if (32'(i_req.byte_length) > i2cms_pkg::C_MAX_BYTES) begin
            v_len = i2cms_pkg::LEN_W'(i2cms_pkg::C_MAX_BYTES);
        end
        v_cnt = i_req.message_count;
        if (v_cnt == '0) begin
            v_cnt = i2cms_pkg::COUNT_W'(1);
        end
        if (32'(v_cnt) > MAX_MESSAGES) begin
            v_cnt = i2cms_pkg::COUNT_W'(MAX_MESSAGES);
        end
    end

    always_comb begin
        o_cmd.kind = i2cms_pkg::K_NONE;
        case (i_req.action)
            i2cms_pkg::ACT_LOAD: begin
                o_cmd.kind = i2cms_pkg::K_LOAD;
            end
            i2cms_pkg::ACT_START: begin
                o_cmd.kind = i2cms_pkg::K_START;
            end
            i2cms_pkg::ACT_EVENT: begin
                if (v_st != '0) begin
                    o_cmd.kind = i2cms_pkg::K_EVENT;
                end
            end
            default: begin
                o_cmd.kind = i2cms_pkg::K_NONE;
            end
        endcase

        o_cmd.slot_ok = (32'(i_req.slot) < TblDepth);
        o_cmd.slot    = i_req.slot;
        o_cmd.desc    = {v_len, i_req.is_read, i_req.target_address & i2cms_pkg::C_ADDR_MASK};
        o_cmd.count   = v_cnt;
        o_cmd.clr     = v_st & i2cms_pkg::C_STATUS_MASK;
        o_cmd.err     = v_bed | v_rxov | v_ald;
        o_cmd.ureset  = v_bed | v_ald;
        if (v_rxov || v_ald) begin
            o_cmd.oc = i2cms_pkg::OC_RETRY;
        end else if (v_st[i2cms_pkg::SB_ACKNAK]) begin
            o_cmd.oc = i2cms_pkg::OC_NO_DEVICE;
        end else begin
            o_cmd.oc = i2cms_pkg::OC_IO_ERROR;
        end
        o_cmd.irf    = v_st[i2cms_pkg::SB_IRF];
        o_cmd.ite    = v_st[i2cms_pkg::SB_ITE];
        o_cmd.rwm    = v_st[i2cms_pkg::SB_RWM];
        o_cmd.msd    = v_st[i2cms_pkg::SB_MSD];
        o_cmd.acknak = v_st[i2cms_pkg::SB_ACKNAK];
        o_cmd.recv   = i_req.received_byte;
        o_cmd.send   = i_req.send_byte;
    end

endmodule

[rtl/core/i2cms_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C message sequencer: command queue
// Two-entry queue between front end and back end; push and pop may happen
// in the same cycle, and a full queue drains one command per cycle while the back end pops.
// ----------------------------------------------------------------------------
module i2cms_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cms_pkg::t_cmd   i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output i2cms_pkg::t_cmd   o_cmd
);

    i2cms_pkg::t_cmd r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // The pointers differ exactly when the fill level is one.
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with fill level");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("push into a full queue");

endmodule

[rtl/core/i2cms_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C message sequencer: back end
// Holds the descriptor table and the transfer state, executes one command
// per cycle while its result register is free or being taken, and registers the resulting controller accesses.
// ----------------------------------------------------------------------------
module i2cms_back #(
    parameter int MAX_MESSAGES = i2cms_pkg::C_MAX_MESSAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  i2cms_pkg::t_cmd     i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output i2cms_pkg::t_result  o_res
);

    localparam int TblDepth = (MAX_MESSAGES < i2cms_pkg::C_SLOT_SPAN)
                            ? MAX_MESSAGES : i2cms_pkg::C_SLOT_SPAN;
    localparam int TblIdxW  = (TblDepth > 1) ? $clog2(TblDepth) : 1;

    logic [15:0]                   r_tbl [TblDepth];
    logic [31:0]                   r_ctrl;
    logic [i2cms_pkg::COUNT_W-1:0] r_cnt;
    logic [i2cms_pkg::INDEX_W-1:0] r_idx;
    logic [i2cms_pkg::LEN_W-1:0]   r_bytes;
    logic                          r_active;
    logic                          r_out_valid;
    i2cms_pkg::t_result            r_out;

    logic [31:0]                   n_ctrl;
    logic [i2cms_pkg::COUNT_W-1:0] n_cnt;
    logic [i2cms_pkg::INDEX_W-1:0] n_idx;
    logic [i2cms_pkg::LEN_W-1:0]   n_bytes;
    logic                          n_active;
    logic                          n_out_valid;
    i2cms_pkg::t_result            n_out;

    logic                          v_last;
    logic                          v_begin;
    logic [31:0]                   v_cr;
    logic [15:0]                   v_desc;
    logic [i2cms_pkg::INDEX_W-1:0] v_open_idx;

    assign o_pop   = i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    assign v_last = ({1'b0, r_idx} + i2cms_pkg::COUNT_W'(1)) == r_cnt;
    // A message is opened either at message 0 by a start or at the next one.
    assign v_open_idx = (i_cmd.kind == i2cms_pkg::K_START) ? '0 : r_idx + 1'b1;
    assign v_desc = (32'(v_open_idx) < TblDepth) ? r_tbl[TblIdxW'(v_open_idx)] : '0;

    always_comb begin
        n_ctrl   = r_ctrl;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_bytes  = r_bytes;
        n_active = r_active;
        n_out    = '0;
        v_begin  = 1'b0;
        v_cr     = r_ctrl & ~(i2cms_pkg::CB_TB | i2cms_pkg::CB_ACKNAK
                              | i2cms_pkg::CB_STOP | i2cms_pkg::CB_START);

        case (i_cmd.kind)
            i2cms_pkg::K_START: begin
                n_cnt    = i_cmd.count;
                n_idx    = '0;
                n_active = 1'b1;
                n_ctrl   = i2cms_pkg::CB_INIT;
                n_out.status_clear = i2cms_pkg::C_STATUS_MASK;
                v_begin  = 1'b1;
            end
            i2cms_pkg::K_EVENT: begin
                if (r_active) begin
                    n_out.status_clear = i_cmd.clr;
                    if (!i_cmd.err) begin
                        if (i_cmd.irf) begin
                            // Received byte: store it, then arm the next read
                            // or move on once the message is complete.
                            if (r_bytes != '0) begin
                                n_out.store_valid = 1'b1;
                                n_out.store_byte  = i_cmd.recv;
                                n_bytes           = r_bytes - 1'b1;
                            end
                            if (!i_cmd.msd && !i_cmd.acknak) begin
                                if (n_bytes != '0) begin
                                    if (n_bytes == i2cms_pkg::LEN_W'(1) && v_last) begin
                                        v_cr = v_cr | i2cms_pkg::CB_STOP
                                                    | i2cms_pkg::CB_ACKNAK;
                                    end
                                    n_ctrl = v_cr | i2cms_pkg::CB_ALDIE | i2cms_pkg::CB_TB;
                                    n_out.control_write = 1'b1;
                                    n_out.control_value = n_ctrl;
                                end else if (!v_last) begin
                                    n_idx   = r_idx + 1'b1;
                                    v_begin = 1'b1;
                                end
                            end
                        end else if (i_cmd.ite && i_cmd.rwm) begin
                            // Address phase of a read finished: arm the first read.
                            if (!i_cmd.msd) begin
                                if (r_bytes == i2cms_pkg::LEN_W'(1) && v_last) begin
                                    v_cr = v_cr | i2cms_pkg::CB_STOP | i2cms_pkg::CB_ACKNAK;
                                end
                                n_ctrl = (v_cr | i2cms_pkg::CB_ALDIE | i2cms_pkg::CB_TB)
                                       & ~i2cms_pkg::CB_DTEIE;
                                n_out.control_write = 1'b1;
                                n_out.control_value = n_ctrl;
                            end
                        end else if (i_cmd.ite) begin
                            if (!i_cmd.msd) begin
                                if (r_bytes != '0) begin
                                    n_out.data_write = 1'b1;
                                    n_out.data_value = i_cmd.send;
                                    n_out.send_taken = 1'b1;
                                    n_bytes          = r_bytes - 1'b1;
                                    if (n_bytes == '0 && v_last) begin
                                        v_cr = v_cr | i2cms_pkg::CB_STOP;
                                    end
                                    n_ctrl = v_cr | i2cms_pkg::CB_ALDIE | i2cms_pkg::CB_TB;
                                    n_out.control_write = 1'b1;
                                    n_out.control_value = n_ctrl;
                                end else if (!v_last) begin
                                    n_idx   = r_idx + 1'b1;
                                    v_begin = 1'b1;
                                end
                            end
                        end
                    end
                    if (i_cmd.err || i_cmd.msd) begin
                        // End of transfer: mask interrupts and report.
                        n_ctrl = n_ctrl & ~i2cms_pkg::CB_INT_ALL;
                        n_out.control_write = 1'b1;
                        n_out.control_value = n_ctrl;
                        n_out.status_clear  = i2cms_pkg::C_STATUS_MASK;
                        n_out.finished      = 1'b1;
                        n_active            = 1'b0;
                        if (i_cmd.err) begin
                            if (i_cmd.ureset) begin
                                n_out.unit_reset = 1'b1;
                                n_ctrl           = '0;
                            end
                            n_out.outcome = i_cmd.oc;
                        end
                    end
                end
            end
            default: begin
                n_ctrl = r_ctrl;
            end
        endcase

        if (v_begin) begin
            // Open a message: load its length and send the address byte.
            n_bytes = v_desc[15:8];
            n_out.data_write = 1'b1;
            n_out.data_value = {v_desc[6:0], v_desc[7]};
            n_ctrl = (n_ctrl & ~i2cms_pkg::CB_STOP) | i2cms_pkg::CB_START
                   | i2cms_pkg::CB_TB | i2cms_pkg::CB_DTEIE;
            n_out.control_write = 1'b1;
            n_out.control_value = n_ctrl;
        end

        n_out.current_message = n_idx;
        n_out_valid = o_pop || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_bytes     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_ctrl   <= n_ctrl;
                r_cnt    <= n_cnt;
                r_idx    <= n_idx;
                r_bytes  <= n_bytes;
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
        if (o_pop && i_cmd.kind == i2cms_pkg::K_LOAD && i_cmd.slot_ok) begin
            r_tbl[TblIdxW'(i_cmd.slot)] <= i_cmd.desc;
        end
    end

    // State only moves together with the result register, so a held result
    // always matches the state it left behind.
    a_msg_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.current_message == r_idx))
        else $error("held result does not match message index");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.finished) |-> !r_active)
        else $error("transfer still active after finishing");

    a_outcome_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.outcome != i2cms_pkg::OC_OK || r_out.unit_reset))
        |-> r_out.finished)
        else $error("error outcome without finish");

endmodule
